// ===== rtl/fcsda_pkg.sv =====
// ----------------------------------------------------------------------------
// fcsda_pkg - shared types and constants for the fault code status keeper
// Entry layout, status bit masks, operation and result codes, register map.
// ----------------------------------------------------------------------------
`default_nettype none

package fcsda_pkg;

  // operation codes carried on the input word
  typedef enum logic [1:0] {
    OP_REPORT    = 2'd0,
    OP_CLEAR     = 2'd1,
    OP_NEW_CYCLE = 2'd2,
    OP_READ      = 2'd3
  } op_t;

  // test result codes (6 and 7 behave as wait)
  localparam logic [2:0] TR_FAIL         = 3'd1;
  localparam logic [2:0] TR_FAIL_NOW     = 3'd2;
  localparam logic [2:0] TR_FAIL_CONFIRM = 3'd3;
  localparam logic [2:0] TR_PASS         = 3'd4;
  localparam logic [2:0] TR_PASS_NOW     = 3'd5;

  // register map
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_STEP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_STEP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_CYCLES = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AGE_CYCLES     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT    = 3'd6;

  // register reset values
  localparam logic [6:0]        RST_FAIL_LIMIT     = 7'd30;
  localparam logic [6:0]        RST_FAIL_STEP      = 7'd2;
  localparam logic signed [7:0] RST_PASS_LIMIT     = -8'sd30;
  localparam logic [6:0]        RST_PASS_STEP      = 7'd2;
  localparam logic [7:0]        RST_CONFIRM_CYCLES = 8'd2;
  localparam logic [7:0]        RST_AGE_CYCLES     = 8'd40;
  localparam logic [5:0]        RST_ENTRY_COUNT    = 6'd32;

  // status byte bits
  localparam logic [7:0] ST_TF      = 8'h01;  // test failed
  localparam logic [7:0] ST_TFTOC   = 8'h02;  // failed this operation cycle
  localparam logic [7:0] ST_PEND    = 8'h04;  // pending
  localparam logic [7:0] ST_CONF    = 8'h08;  // confirmed
  localparam logic [7:0] ST_TNCSLC  = 8'h10;  // not completed since clear
  localparam logic [7:0] ST_TFSLC   = 8'h20;  // failed since clear
  localparam logic [7:0] ST_TNCTOC  = 8'h40;  // not completed this cycle
  localparam logic [7:0] ST_CLEARED = 8'h50;

  // pending count saturation value
  localparam logic [7:0] PEND_MAX = 8'hff;

  // one table entry as stored in the memory
  typedef struct packed {
    logic [7:0]        status;
    logic signed [7:0] debounce;
    logic [7:0]        pending;
    logic [7:0]        aging;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{ST_CLEARED, 8'sd0, 8'd0, 8'd0};

  // debounce and aging settings seen by the update logic
  typedef struct packed {
    logic [6:0]        fail_limit;
    logic [6:0]        fail_step;
    logic signed [7:0] pass_limit;
    logic [6:0]        pass_step;
    logic [7:0]        confirm_cycles;
    logic [7:0]        age_cycles;
  } cfg_t;

  // what the update logic is asked to do with the entry
  typedef struct packed {
    op_t        op;
    logic [2:0] code;
    logic       in_use;
  } upd_ctl_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_SWEEP,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/fault_code_status_debounce_aging_core.sv =====
// ----------------------------------------------------------------------------
// fault_code_status_debounce_aging_core - fault code status keeper
// Status byte, debounce counter, pending and aging counts per fault entry.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_*): one word per operation - report, clear, new
//   operation cycle or read - on the entry given by in_entry_index.
//   Output channel (out_*): exactly one word per input word, in order, with
//   the entry's status after the operation and the snapshot request.
//   cfg_*: register writes, taken whenever cfg_we is high; write only when
//   no operation is outstanding.
// Timing
//   Report, read and single clear: one read-modify-write of the entry
//   memory; read on acceptance, then written back and the result registered
//   in S_RMW once the output register is free. New cycle: a sweep over all
//   ENTRIES entries at one entry per cycle. Clear all: a sweep over the
//   entries in use. The memory's single read port sets the pace.
// Reset
//   Synchronous, active low. Registers return to their defaults and a row of
//   per-entry valid bits marks every entry as cleared at once: no clearing
//   pass. A waiting result holds while out_ready is low; the next word is
//   accepted meanwhile and finishes once the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module fault_code_status_debounce_aging_core #(
  parameter int ENTRIES = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_op,
  input  wire logic [4:0]                     in_entry_index,
  input  wire logic                           in_clear_all,
  input  wire logic [2:0]                     in_test_result,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [7:0]                          out_status_byte,
  output logic                                out_snapshot_capture,
  output logic                                out_index_valid,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [fcsda_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_wdata
);

  localparam int AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int NW  = $clog2(ENTRIES + 1);
  localparam int CW  = (NW > 6) ? NW : 6;
  localparam int EW  = $bits(fcsda_pkg::entry_t);

  // configuration registers
  logic [6:0]        fail_limit_r;
  logic [6:0]        fail_step_r;
  logic signed [7:0] pass_limit_r;
  logic [6:0]        pass_step_r;
  logic [7:0]        confirm_cycles_r;
  logic [7:0]        age_cycles_r;
  logic [5:0]        entry_count_r;

  // sequencer and operation registers
  fcsda_pkg::state_t state_r, state_nxt;
  fcsda_pkg::op_t    op_r;
  logic [4:0]        idx_r;
  logic [2:0]        code_r;
  logic              valid_r;
  logic [AW-1:0]     sweep_cnt_r;
  logic [AW-1:0]     sweep_last_r;
  logic [7:0]        cap_status_r;

  // entry memory side
  logic [ENTRIES-1:0] vld_r;
  logic               rd_vld_r;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [EW-1:0]      ram_q;

  // output register
  logic       out_valid_r;
  logic [7:0] out_status_r;
  logic       out_snap_r;
  logic       out_ivld_r;

  logic                  in_acc;
  logic                  out_free;
  logic                  out_load;
  logic                  sweep_req;
  logic                  sweep_empty;
  logic                  sweep_end;
  logic [CW-1:0]         n_use;
  logic [CW-1:0]         ec_ext;
  logic                  idx_ok;
  fcsda_pkg::op_t        in_op_e;
  fcsda_pkg::cfg_t       cfg;
  fcsda_pkg::upd_ctl_t   upd_ctl;
  fcsda_pkg::entry_t     ent_cur;
  fcsda_pkg::entry_t     ent_nxt;
  logic                  upd_snap;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_limit_r     <= fcsda_pkg::RST_FAIL_LIMIT;
      fail_step_r      <= fcsda_pkg::RST_FAIL_STEP;
      pass_limit_r     <= fcsda_pkg::RST_PASS_LIMIT;
      pass_step_r      <= fcsda_pkg::RST_PASS_STEP;
      confirm_cycles_r <= fcsda_pkg::RST_CONFIRM_CYCLES;
      age_cycles_r     <= fcsda_pkg::RST_AGE_CYCLES;
      entry_count_r    <= fcsda_pkg::RST_ENTRY_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        fcsda_pkg::CFG_FAIL_LIMIT:     fail_limit_r     <= cfg_wdata[6:0];
        fcsda_pkg::CFG_FAIL_STEP:      fail_step_r      <= cfg_wdata[6:0];
        fcsda_pkg::CFG_PASS_LIMIT:     pass_limit_r     <= cfg_wdata;
        fcsda_pkg::CFG_PASS_STEP:      pass_step_r      <= cfg_wdata[6:0];
        fcsda_pkg::CFG_CONFIRM_CYCLES: confirm_cycles_r <= cfg_wdata;
        fcsda_pkg::CFG_AGE_CYCLES:     age_cycles_r     <= cfg_wdata;
        fcsda_pkg::CFG_ENTRY_COUNT:    entry_count_r    <= cfg_wdata[5:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = '{fail_limit_r, fail_step_r, pass_limit_r, pass_step_r,
                 confirm_cycles_r, age_cycles_r};

  // entries in use and index check
  assign ec_ext = CW'(entry_count_r);
  assign n_use  = (ec_ext < CW'(ENTRIES)) ? ec_ext : CW'(ENTRIES);
  assign idx_ok = CW'(in_entry_index) < n_use;

  assign in_op_e     = fcsda_pkg::op_t'(in_op);
  assign in_acc      = in_valid && in_ready;
  assign out_free    = !out_valid_r || out_ready;
  assign sweep_req   = (in_op_e == fcsda_pkg::OP_NEW_CYCLE) ||
                       ((in_op_e == fcsda_pkg::OP_CLEAR) && in_clear_all);
  assign sweep_empty = (in_op_e == fcsda_pkg::OP_CLEAR) && (n_use == '0);
  assign sweep_end   = sweep_cnt_r == sweep_last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fcsda_pkg::S_IDLE: begin
        if (in_valid) begin
          if (!sweep_req) begin
            state_nxt = fcsda_pkg::S_RMW;
          end else if (sweep_empty) begin
            state_nxt = fcsda_pkg::S_FIN;
          end else begin
            state_nxt = fcsda_pkg::S_SWEEP;
          end
        end
      end
      fcsda_pkg::S_RMW: begin
        if (out_free) begin
          state_nxt = fcsda_pkg::S_IDLE;
        end
      end
      fcsda_pkg::S_SWEEP: begin
        if (sweep_end) begin
          state_nxt = fcsda_pkg::S_FIN;
        end
      end
      fcsda_pkg::S_FIN: begin
        if (out_free) begin
          state_nxt = fcsda_pkg::S_IDLE;
        end
      end
      default: state_nxt = fcsda_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs: memory ports and result load
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = sweep_cnt_r;
    out_load = 1'b0;
    case (state_r)
      fcsda_pkg::S_IDLE: begin
        in_ready = 1'b1;
        rd_en    = in_valid;
        rd_addr  = sweep_req ? '0 : AW'(in_entry_index);
      end
      fcsda_pkg::S_RMW: begin
        wr_addr = AW'(idx_r);
        if (out_free) begin
          out_load = 1'b1;
          wr_en    = valid_r &&
                     ((op_r == fcsda_pkg::OP_REPORT) || (op_r == fcsda_pkg::OP_CLEAR));
        end
      end
      fcsda_pkg::S_SWEEP: begin
        wr_en = 1'b1;
        if (!sweep_end) begin
          rd_en   = 1'b1;
          rd_addr = sweep_cnt_r + AW'(1);
        end
      end
      fcsda_pkg::S_FIN: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcsda_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // operation capture and sweep counter
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r         <= in_op_e;
      idx_r        <= in_entry_index;
      code_r       <= in_test_result;
      valid_r      <= idx_ok;
      sweep_cnt_r  <= '0;
      sweep_last_r <= (in_op_e == fcsda_pkg::OP_NEW_CYCLE) ? AW'(ENTRIES - 1)
                                                           : AW'(n_use - CW'(1));
    end else if ((state_r == fcsda_pkg::S_SWEEP) && !sweep_end) begin
      sweep_cnt_r <= sweep_cnt_r + AW'(1);
    end
  end

  // status of the addressed entry as the sweep passes it
  always_ff @(posedge clk) begin
    if ((state_r == fcsda_pkg::S_SWEEP) && (sweep_cnt_r == AW'(idx_r))) begin
      cap_status_r <= ent_nxt.status;
    end
  end

  // per-entry written marks; an unwritten entry reads as cleared
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  fcsda_ram #(
    .WIDTH (EW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (ent_nxt),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  assign ent_cur = rd_vld_r ? fcsda_pkg::entry_t'(ram_q) : fcsda_pkg::ENTRY_RESET;
  assign upd_ctl = '{op_r, code_r, (CW'(sweep_cnt_r) < n_use)};

  fcsda_upd u_upd (
    .cfg  (cfg),
    .ctl  (upd_ctl),
    .cur  (ent_cur),
    .nxt  (ent_nxt),
    .snap (upd_snap)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ivld_r <= valid_r;
      if (state_r == fcsda_pkg::S_RMW) begin
        out_status_r <= valid_r ? ent_nxt.status : 8'h00;
        out_snap_r   <= valid_r && (op_r == fcsda_pkg::OP_REPORT) && upd_snap;
      end else begin
        out_status_r <= valid_r ? cap_status_r : 8'h00;
        out_snap_r   <= 1'b0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status_byte      = out_status_r;
  assign out_snapshot_capture = out_snap_r;
  assign out_index_valid      = out_ivld_r;

endmodule

`default_nettype wire

// ===== rtl/fcsda_ram.sv =====
// ----------------------------------------------------------------------------
// fcsda_ram - generic simple dual-port RAM
// One write port, one read port, read data registered and held between reads.
// ----------------------------------------------------------------------------
`default_nettype none

module fcsda_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fcsda_upd.sv =====
// ----------------------------------------------------------------------------
// fcsda_upd - entry update logic
// Applies a report, a clear or the new-cycle aging step to one table entry.
// ----------------------------------------------------------------------------
`default_nettype none

module fcsda_upd (
  input  wire fcsda_pkg::cfg_t     cfg,
  input  wire fcsda_pkg::upd_ctl_t ctl,
  input  wire fcsda_pkg::entry_t   cur,
  output fcsda_pkg::entry_t        nxt,
  output logic                     snap
);

  logic signed [8:0] cnt9;
  logic signed [8:0] fail_thr;
  logic signed [8:0] pass_thr;
  logic              is_fail;
  logic              is_pass;
  logic              fail_hit;
  logic              pass_hit;
  logic [7:0]        pend_inc;

  // threshold compares at nine bits so the sums cannot wrap
  assign cnt9     = {cur.debounce[7], cur.debounce};
  assign fail_thr = $signed({2'b00, cfg.fail_limit}) - $signed({2'b00, cfg.fail_step});
  assign pass_thr = $signed({cfg.pass_limit[7], cfg.pass_limit})
                  + $signed({2'b00, cfg.pass_step});

  assign is_fail  = (ctl.code == fcsda_pkg::TR_FAIL) || (ctl.code == fcsda_pkg::TR_FAIL_NOW) ||
                    (ctl.code == fcsda_pkg::TR_FAIL_CONFIRM);
  assign is_pass  = (ctl.code == fcsda_pkg::TR_PASS) || (ctl.code == fcsda_pkg::TR_PASS_NOW);
  assign fail_hit = (cnt9 >= fail_thr) || (ctl.code != fcsda_pkg::TR_FAIL);
  assign pass_hit = (cnt9 <= pass_thr) || (ctl.code == fcsda_pkg::TR_PASS_NOW);

  // saturating pending count
  assign pend_inc = (cur.pending != fcsda_pkg::PEND_MAX) ? cur.pending + 8'd1 : cur.pending;

  always_comb begin
    logic [7:0]        st;
    logic signed [7:0] cnt_v;
    logic [7:0]        pend_v;
    logic [7:0]        aging_v;

    st      = cur.status;
    cnt_v   = cur.debounce;
    pend_v  = cur.pending;
    aging_v = cur.aging;
    snap    = 1'b0;

    case (ctl.op)
      fcsda_pkg::OP_REPORT: begin
        if (is_fail) begin
          if (fail_hit) begin
            cnt_v = $signed({1'b0, cfg.fail_limit});
            // first failure in this cycle
            if ((st & fcsda_pkg::ST_TFTOC) == 8'h00) begin
              st     = st | fcsda_pkg::ST_TFTOC | fcsda_pkg::ST_PEND;
              pend_v = pend_inc;
              if ((pend_inc >= cfg.confirm_cycles) ||
                  (ctl.code == fcsda_pkg::TR_FAIL_CONFIRM)) begin
                pend_v = cfg.confirm_cycles;
                st     = st | fcsda_pkg::ST_CONF;
                snap   = 1'b1;
              end
            end
            st = (st | fcsda_pkg::ST_TF | fcsda_pkg::ST_TFSLC) &
                 ~(fcsda_pkg::ST_TNCTOC | fcsda_pkg::ST_TNCSLC);
          end else begin
            cnt_v = cnt_v + $signed({1'b0, cfg.fail_step});
          end
        end else if (is_pass) begin
          if (pass_hit) begin
            cnt_v = cfg.pass_limit;
            st    = st & ~(fcsda_pkg::ST_TF | fcsda_pkg::ST_TNCTOC | fcsda_pkg::ST_TNCSLC);
          end else begin
            cnt_v = cnt_v - $signed({1'b0, cfg.pass_step});
          end
        end
      end

      // aging count survives a clear
      fcsda_pkg::OP_CLEAR: begin
        st     = fcsda_pkg::ST_CLEARED;
        cnt_v  = 8'sd0;
        pend_v = 8'd0;
      end

      fcsda_pkg::OP_NEW_CYCLE: begin
        // aging, only for tests completed in the closing cycle
        if ((st & fcsda_pkg::ST_TNCTOC) == 8'h00) begin
          if ((st & fcsda_pkg::ST_TFTOC) != 8'h00) begin
            aging_v = 8'd0;
          end else begin
            if (cur.aging >= cfg.age_cycles) begin
              st = st & ~(fcsda_pkg::ST_TFSLC | fcsda_pkg::ST_CONF);
            end else begin
              aging_v = cur.aging + 8'd1;
            end
            pend_v = 8'd0;
            st     = st & ~fcsda_pkg::ST_PEND;
          end
        end
        // per-cycle reset of entries in use
        if (ctl.in_use) begin
          st    = (st & ~(fcsda_pkg::ST_TF | fcsda_pkg::ST_TFTOC)) | fcsda_pkg::ST_TNCTOC;
          cnt_v = 8'sd0;
        end
      end

      default: begin
      end
    endcase

    nxt = '{st, cnt_v, pend_v, aging_v};
  end

endmodule

`default_nettype wire

// ===== rtl/fcsda_chk.sv =====
// ----------------------------------------------------------------------------
// fcsda_chk - port-level checks for the fault code status keeper
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fcsda_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_status_byte,
  input wire logic       out_snapshot_capture,
  input wire logic       out_index_valid
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status_byte) &&
    $stable(out_snapshot_capture) && $stable(out_index_valid))
    else $error("result word changed while stalled");

  // reset empties the output register and leaves the block ready
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // out-of-range entry gives an all-zero word
  a_bad_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_index_valid |-> out_status_byte == 8'h00 && !out_snapshot_capture)
    else $error("invalid index word carries data");

  // a snapshot request means a fresh confirmed failure in this cycle
  a_snap_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_snapshot_capture |->
    out_status_byte[0] && out_status_byte[1] && out_status_byte[2] &&
    out_status_byte[3] && out_status_byte[5] && !out_status_byte[6] &&
    !out_status_byte[4])
    else $error("snapshot without confirmed failure status");

  // warning indicator is never raised
  a_no_warning: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_status_byte[7])
    else $error("warning bit set");

endmodule

bind fault_code_status_debounce_aging_core fcsda_chk u_fcsda_chk (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_status_byte      (out_status_byte),
  .out_snapshot_capture (out_snapshot_capture),
  .out_index_valid      (out_index_valid)
);

`default_nettype wire

// ===== verif/tb_fault_code_status_debounce_aging_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fault_code_status_debounce_aging_core - self-checking bench for the core
// A short table of directed words runs first, then phases of random report
// bursts, clears, reads and new operation cycles under several register
// settings. Every result word is checked against an in-bench model of the
// fault table or a typed value, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_fault_code_status_debounce_aging_core;

  localparam int ENTRIES       = 32;
  localparam int SETTLE_CYCLES = ENTRIES + 4;
  localparam int PHASE_WORDS   = 100;
  localparam int RANDOM_PHASES = 8;

  // result codes the package leaves unnamed; 6 and 7 act as wait
  localparam logic [2:0] TR_WAIT   = 3'd0;
  localparam logic [2:0] TR_RSVD_6 = 3'd6;
  localparam logic [2:0] TR_RSVD_7 = 3'd7;

  typedef struct packed {
    fcsda_pkg::op_t op;
    logic [4:0]     entry_index;
    logic           clear_all;
    logic [2:0]     test_result;
  } fault_cmd_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic       snapshot_capture;
    logic       index_valid;
  } status_word_t;

  typedef enum logic [1:0] {
    ROW_WORD,   // result taken from the model
    ROW_TYPED,  // result written into the table
    ROW_REG     // register write, block idle
  } row_kind_t;

  typedef struct packed {
    row_kind_t                       kind;
    fault_cmd_t                      cmd;
    logic [fcsda_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [7:0]                      reg_val;
    status_word_t                    want;
  } plan_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic [1:0]                      in_op;
  logic [4:0]                      in_entry_index;
  logic                            in_clear_all;
  logic [2:0]                      in_test_result;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [7:0]                      out_status_byte;
  logic                            out_snapshot_capture;
  logic                            out_index_valid;
  logic                            cfg_we;
  logic [fcsda_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                      cfg_wdata;

  // register shadow
  logic [6:0] fail_limit_q;
  logic [6:0] fail_step_q;
  int         pass_limit_q;
  logic [6:0] pass_step_q;
  logic [7:0] confirm_q;
  logic [7:0] age_q;
  logic [5:0] entry_count_q;

  // fault table shadow
  logic [7:0] status_tbl  [ENTRIES];
  int         debounce_tbl[ENTRIES];
  logic [7:0] pending_tbl [ENTRIES];
  logic [7:0] aging_tbl   [ENTRIES];

  status_word_t status_due[$];
  plan_row_t    dir_plan[$];

  bit no_idle       = 1'b0;
  int words_sent    = 0;
  int words_checked = 0;
  int snaps_seen    = 0;
  int invalid_seen  = 0;
  int reg_writes    = 0;
  int mismatches    = 0;

  fault_code_status_debounce_aging_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_op                (in_op),
    .in_entry_index       (in_entry_index),
    .in_clear_all         (in_clear_all),
    .in_test_result       (in_test_result),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status_byte      (out_status_byte),
    .out_snapshot_capture (out_snapshot_capture),
    .out_index_valid      (out_index_valid),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int entries_in_use();
    return (int'(entry_count_q) < ENTRIES) ? int'(entry_count_q) : ENTRIES;
  endfunction

  // apply one operation word to the shadow table, return the word it yields
  function automatic status_word_t apply_fault_op(fault_cmd_t c);
    status_word_t r;
    int           n;
    int           idx;
    int           cnt;
    bit           ok;
    logic [7:0]   st;
    n   = entries_in_use();
    idx = int'(c.entry_index);
    ok  = idx < n;
    r.snapshot_capture = 1'b0;
    case (c.op)
      fcsda_pkg::OP_REPORT: begin
        if (ok) begin
          cnt = debounce_tbl[idx];
          st  = status_tbl[idx];
          if (c.test_result == fcsda_pkg::TR_FAIL ||
              c.test_result == fcsda_pkg::TR_FAIL_NOW ||
              c.test_result == fcsda_pkg::TR_FAIL_CONFIRM) begin
            if (cnt >= int'(fail_limit_q) - int'(fail_step_q) ||
                c.test_result != fcsda_pkg::TR_FAIL) begin
              cnt = int'(fail_limit_q);
              // first failure this cycle: pending count and confirmation
              if ((st & fcsda_pkg::ST_TFTOC) == 8'h00) begin
                st = st | fcsda_pkg::ST_TFTOC;
                if (pending_tbl[idx] != fcsda_pkg::PEND_MAX)
                  pending_tbl[idx] = pending_tbl[idx] + 8'd1;
                if (pending_tbl[idx] >= confirm_q ||
                    c.test_result == fcsda_pkg::TR_FAIL_CONFIRM) begin
                  pending_tbl[idx]   = confirm_q;
                  st                 = st | fcsda_pkg::ST_CONF;
                  r.snapshot_capture = 1'b1;
                end
                st = st | fcsda_pkg::ST_PEND;
              end
              st = (st | fcsda_pkg::ST_TF | fcsda_pkg::ST_TFSLC) &
                   ~(fcsda_pkg::ST_TNCTOC | fcsda_pkg::ST_TNCSLC);
            end else begin
              cnt = cnt + int'(fail_step_q);
            end
          end else if (c.test_result == fcsda_pkg::TR_PASS ||
                       c.test_result == fcsda_pkg::TR_PASS_NOW) begin
            if (cnt <= pass_limit_q + int'(pass_step_q) ||
                c.test_result == fcsda_pkg::TR_PASS_NOW) begin
              cnt = pass_limit_q;
              st  = st & ~(fcsda_pkg::ST_TF | fcsda_pkg::ST_TNCTOC | fcsda_pkg::ST_TNCSLC);
            end else begin
              cnt = cnt - int'(pass_step_q);
            end
          end
          debounce_tbl[idx] = cnt;
          status_tbl[idx]   = st;
        end
      end
      fcsda_pkg::OP_CLEAR: begin
        // aging count survives a clear
        for (int i = 0; i < ENTRIES; i++) begin
          if ((c.clear_all && i < n) || (!c.clear_all && ok && i == idx)) begin
            status_tbl[i]   = fcsda_pkg::ST_CLEARED;
            debounce_tbl[i] = 0;
            pending_tbl[i]  = 8'd0;
          end
        end
      end
      fcsda_pkg::OP_NEW_CYCLE: begin
        // aging sweeps the whole table, completed entries only
        for (int i = 0; i < ENTRIES; i++) begin
          st = status_tbl[i];
          if ((st & fcsda_pkg::ST_TNCTOC) == 8'h00) begin
            if ((st & fcsda_pkg::ST_TFTOC) != 8'h00) begin
              aging_tbl[i] = 8'd0;
            end else begin
              if (aging_tbl[i] >= age_q)
                st = st & ~(fcsda_pkg::ST_TFSLC | fcsda_pkg::ST_CONF);
              else
                aging_tbl[i] = aging_tbl[i] + 8'd1;
              pending_tbl[i] = 8'd0;
              st = st & ~fcsda_pkg::ST_PEND;
            end
            status_tbl[i] = st;
          end
        end
        // per-cycle bits reset on entries in use only
        for (int i = 0; i < n; i++) begin
          status_tbl[i]   = (status_tbl[i] & ~(fcsda_pkg::ST_TF | fcsda_pkg::ST_TFTOC)) |
                            fcsda_pkg::ST_TNCTOC;
          debounce_tbl[i] = 0;
        end
      end
      default: ;
    endcase
    r.status_byte = ok ? status_tbl[idx] : 8'h00;
    r.index_valid = ok;
    return r;
  endfunction

  function automatic void plan_word(fcsda_pkg::op_t op, logic [4:0] idx, logic all,
                                    logic [2:0] code);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_WORD;
    row.cmd  = '{op, idx, all, code};
    dir_plan.push_back(row);
  endfunction

  function automatic void plan_typed(fcsda_pkg::op_t op, logic [4:0] idx, logic all,
                                     logic [2:0] code, logic [7:0] st, logic snap,
                                     logic vld);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_TYPED;
    row.cmd  = '{op, idx, all, code};
    row.want = '{st, snap, vld};
    dir_plan.push_back(row);
  endfunction

  function automatic void plan_reg(logic [fcsda_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    plan_row_t row;
    row         = '0;
    row.kind    = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    dir_plan.push_back(row);
  endfunction

  // offer one word, hold it until taken, then queue what it should yield
  task automatic send_word(input fault_cmd_t c, input bit typed, input status_word_t want);
    status_word_t pred;
    if (!no_idle && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 9);
    end
    in_valid       <= 1'b1;
    in_op          <= c.op;
    in_entry_index <= c.entry_index;
    in_clear_all   <= c.clear_all;
    in_test_result <= c.test_result;
    do @(posedge clk); while (!in_ready);
    pred = apply_fault_op(c);
    status_due.push_back(typed ? want : pred);
    words_sent++;
  endtask

  // stop sending and let the block drain completely
  task automatic settle();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg_we is left high; the caller lowers it after the last write
  task automatic write_reg(input logic [fcsda_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      fcsda_pkg::CFG_FAIL_LIMIT:     fail_limit_q  = val[6:0];
      fcsda_pkg::CFG_FAIL_STEP:      fail_step_q   = val[6:0];
      fcsda_pkg::CFG_PASS_LIMIT:     pass_limit_q  = int'($signed(val));
      fcsda_pkg::CFG_PASS_STEP:      pass_step_q   = val[6:0];
      fcsda_pkg::CFG_CONFIRM_CYCLES: confirm_q     = val;
      fcsda_pkg::CFG_AGE_CYCLES:     age_q         = val;
      fcsda_pkg::CFG_ENTRY_COUNT:    entry_count_q = val[5:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_regs(input logic [7:0] fl, input logic [7:0] fs, input logic [7:0] pl,
                          input logic [7:0] ps, input logic [7:0] cc, input logic [7:0] ac,
                          input logic [7:0] ec);
    settle();
    write_reg(fcsda_pkg::CFG_FAIL_LIMIT, fl);
    write_reg(fcsda_pkg::CFG_FAIL_STEP, fs);
    write_reg(fcsda_pkg::CFG_PASS_LIMIT, pl);
    write_reg(fcsda_pkg::CFG_PASS_STEP, ps);
    write_reg(fcsda_pkg::CFG_CONFIRM_CYCLES, cc);
    write_reg(fcsda_pkg::CFG_AGE_CYCLES, ac);
    write_reg(fcsda_pkg::CFG_ENTRY_COUNT, ec);
    cfg_we <= 1'b0;
  endtask

  // mostly a few low entries so debounce builds up, sometimes anywhere
  function automatic logic [4:0] aim_entry(int n);
    if (n == 0 || $urandom_range(15) == 0)
      return 5'($urandom);
    if ($urandom_range(3) != 0)
      return 5'($urandom_range((n < 4 ? n : 4) - 1));
    return 5'($urandom_range(n - 1));
  endfunction

  // one random step: a burst of reports in one direction, or a single word
  task automatic random_burst();
    fault_cmd_t c;
    int         n;
    int         pick;
    int         code_pick;
    bit         fail_dir;
    n    = entries_in_use();
    pick = $urandom_range(99);
    c.op          = fcsda_pkg::OP_READ;
    c.entry_index = aim_entry(n);
    c.clear_all   = 1'($urandom);
    c.test_result = 3'($urandom);
    if (pick < 10) begin
      // noise
      c.op          = fcsda_pkg::op_t'($urandom_range(3));
      c.entry_index = 5'($urandom);
      send_word(c, 1'b0, '0);
    end else if (pick < 65) begin
      c.op     = fcsda_pkg::OP_REPORT;
      fail_dir = 1'($urandom);
      repeat ($urandom_range(1, 16)) begin
        code_pick = $urandom_range(15);
        if (fail_dir)
          c.test_result = (code_pick == 0) ? fcsda_pkg::TR_FAIL_CONFIRM :
                          (code_pick < 3)  ? fcsda_pkg::TR_FAIL_NOW : fcsda_pkg::TR_FAIL;
        else
          c.test_result = (code_pick < 2) ? fcsda_pkg::TR_PASS_NOW : fcsda_pkg::TR_PASS;
        send_word(c, 1'b0, '0);
      end
    end else if (pick < 77) begin
      c.op = fcsda_pkg::OP_NEW_CYCLE;
      send_word(c, 1'b0, '0);
    end else if (pick < 89) begin
      send_word(c, 1'b0, '0);
    end else begin
      c.op        = fcsda_pkg::OP_CLEAR;
      c.clear_all = ($urandom_range(3) == 0);
      send_word(c, 1'b0, '0);
    end
  endtask

  // receiver idling
  always @(posedge clk)
    out_ready <= no_idle || ($urandom_range(99) >= 9);

  // result checker
  always @(posedge clk) begin : check_out
    status_word_t due;
    if (rst_n && out_valid && out_ready) begin
      if (status_due.size() == 0) begin
        $error("result word with nothing expected: status_byte %02h", out_status_byte);
        mismatches++;
      end else begin
        due = status_due.pop_front();
        if (out_status_byte !== due.status_byte) begin
          $error("status_byte: expected %02h, got %02h", due.status_byte, out_status_byte);
          mismatches++;
        end
        if (out_snapshot_capture !== due.snapshot_capture) begin
          $error("snapshot_capture: expected %0b, got %0b",
                 due.snapshot_capture, out_snapshot_capture);
          mismatches++;
        end
        if (out_index_valid !== due.index_valid) begin
          $error("index_valid: expected %0b, got %0b", due.index_valid, out_index_valid);
          mismatches++;
        end
        words_checked++;
        if (due.snapshot_capture) snaps_seen++;
        if (!due.index_valid) invalid_seen++;
      end
    end
  end

  initial begin : stimulus
    plan_row_t row;
    bit        reg_open;
    int        phase_end;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_op          = fcsda_pkg::OP_READ;
    in_entry_index = '0;
    in_clear_all   = 1'b0;
    in_test_result = TR_WAIT;
    cfg_we         = 1'b0;
    cfg_index      = fcsda_pkg::CFG_FAIL_LIMIT;
    cfg_wdata      = '0;
    fail_limit_q   = fcsda_pkg::RST_FAIL_LIMIT;
    fail_step_q    = fcsda_pkg::RST_FAIL_STEP;
    pass_limit_q   = int'(fcsda_pkg::RST_PASS_LIMIT);
    pass_step_q    = fcsda_pkg::RST_PASS_STEP;
    confirm_q      = fcsda_pkg::RST_CONFIRM_CYCLES;
    age_q          = fcsda_pkg::RST_AGE_CYCLES;
    entry_count_q  = fcsda_pkg::RST_ENTRY_COUNT;
    for (int i = 0; i < ENTRIES; i++) begin
      status_tbl[i]   = fcsda_pkg::ST_CLEARED;
      debounce_tbl[i] = 0;
      pending_tbl[i]  = 8'd0;
      aging_tbl[i]    = 8'd0;
    end

    // directed table: reset values, wait codes, debounce, clears, cycles
    plan_typed(fcsda_pkg::OP_READ,   5'd0,  1'b0, TR_WAIT,
               fcsda_pkg::ST_CLEARED, 1'b0, 1'b1);
    plan_typed(fcsda_pkg::OP_READ,   5'd31, 1'b0, TR_WAIT,
               fcsda_pkg::ST_CLEARED, 1'b0, 1'b1);
    plan_typed(fcsda_pkg::OP_REPORT, 5'd0,  1'b0, TR_WAIT,
               fcsda_pkg::ST_CLEARED, 1'b0, 1'b1);
    plan_typed(fcsda_pkg::OP_REPORT, 5'd0,  1'b0, TR_RSVD_6,
               fcsda_pkg::ST_CLEARED, 1'b0, 1'b1);
    plan_typed(fcsda_pkg::OP_REPORT, 5'd0,  1'b0, TR_RSVD_7,
               fcsda_pkg::ST_CLEARED, 1'b0, 1'b1);
    plan_word (fcsda_pkg::OP_REPORT,    5'd1,  1'b0, fcsda_pkg::TR_FAIL);
    plan_word (fcsda_pkg::OP_REPORT,    5'd2,  1'b0, fcsda_pkg::TR_FAIL_NOW);
    plan_typed(fcsda_pkg::OP_REPORT,    5'd3,  1'b0, fcsda_pkg::TR_FAIL_CONFIRM,
               fcsda_pkg::ST_TF | fcsda_pkg::ST_TFTOC | fcsda_pkg::ST_PEND |
               fcsda_pkg::ST_CONF | fcsda_pkg::ST_TFSLC, 1'b1, 1'b1);
    plan_word (fcsda_pkg::OP_REPORT,    5'd3,  1'b0, fcsda_pkg::TR_PASS_NOW);
    plan_word (fcsda_pkg::OP_REPORT,    5'd4,  1'b0, fcsda_pkg::TR_PASS);
    plan_word (fcsda_pkg::OP_CLEAR,     5'd3,  1'b0, TR_WAIT);
    plan_word (fcsda_pkg::OP_NEW_CYCLE, 5'd2,  1'b0, TR_WAIT);
    plan_word (fcsda_pkg::OP_REPORT,    5'd2,  1'b0, fcsda_pkg::TR_FAIL_NOW);
    plan_word (fcsda_pkg::OP_CLEAR,     5'd5,  1'b1, fcsda_pkg::TR_PASS);
    // no entries in use: everything out of range
    plan_reg  (fcsda_pkg::CFG_ENTRY_COUNT, 8'd0);
    plan_typed(fcsda_pkg::OP_READ,      5'd0,  1'b0, TR_WAIT,     8'h00, 1'b0, 1'b0);
    plan_typed(fcsda_pkg::OP_REPORT,    5'd31, 1'b0, fcsda_pkg::TR_FAIL_NOW,
               8'h00, 1'b0, 1'b0);
    plan_typed(fcsda_pkg::OP_CLEAR,     5'd7,  1'b0, TR_WAIT,     8'h00, 1'b0, 1'b0);
    plan_typed(fcsda_pkg::OP_NEW_CYCLE, 5'd0,  1'b0, TR_WAIT,     8'h00, 1'b0, 1'b0);
    // extreme limits, pending count saturating, instant aging
    plan_reg  (fcsda_pkg::CFG_FAIL_LIMIT,     8'd127);
    plan_reg  (fcsda_pkg::CFG_FAIL_STEP,      8'd127);
    plan_reg  (fcsda_pkg::CFG_PASS_LIMIT,     8'h80);
    plan_reg  (fcsda_pkg::CFG_PASS_STEP,      8'd127);
    plan_reg  (fcsda_pkg::CFG_CONFIRM_CYCLES, 8'd255);
    plan_reg  (fcsda_pkg::CFG_AGE_CYCLES,     8'd0);
    plan_reg  (fcsda_pkg::CFG_ENTRY_COUNT,    8'd4);
    plan_word (fcsda_pkg::OP_REPORT,    5'd1,  1'b0, fcsda_pkg::TR_FAIL_CONFIRM);
    plan_word (fcsda_pkg::OP_NEW_CYCLE, 5'd1,  1'b0, TR_WAIT);
    plan_word (fcsda_pkg::OP_REPORT,    5'd1,  1'b0, fcsda_pkg::TR_FAIL_NOW);
    plan_word (fcsda_pkg::OP_REPORT,    5'd3,  1'b0, fcsda_pkg::TR_FAIL);
    plan_word (fcsda_pkg::OP_REPORT,    5'd3,  1'b0, fcsda_pkg::TR_PASS);
    plan_typed(fcsda_pkg::OP_CLEAR,     5'd9,  1'b1, TR_WAIT,     8'h00, 1'b0, 1'b0);
    plan_word (fcsda_pkg::OP_NEW_CYCLE, 5'd2,  1'b0, TR_WAIT);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    reg_open = 1'b0;
    foreach (dir_plan[k]) begin
      row = dir_plan[k];
      if (row.kind == ROW_REG) begin
        if (!reg_open) settle();
        write_reg(row.reg_idx, row.reg_val);
        reg_open = 1'b1;
      end else begin
        if (reg_open) cfg_we <= 1'b0;
        reg_open = 1'b0;
        send_word(row.cmd, row.kind == ROW_TYPED, row.want);
      end
    end

    // random phases, each under its own register setting
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_regs({1'b0, fcsda_pkg::RST_FAIL_LIMIT}, {1'b0, fcsda_pkg::RST_FAIL_STEP},
                    fcsda_pkg::RST_PASS_LIMIT, {1'b0, fcsda_pkg::RST_PASS_STEP},
                    fcsda_pkg::RST_CONFIRM_CYCLES, fcsda_pkg::RST_AGE_CYCLES,
                    {2'b00, fcsda_pkg::RST_ENTRY_COUNT});
        1: set_regs(8'd1, 8'd1, 8'hff, 8'd1, 8'd1, 8'd0, 8'd1);
        2: set_regs(8'd127, 8'd127, 8'h80, 8'd127, 8'd255, 8'd255, 8'd32);
        default:
          set_regs(($urandom_range(4) == 0) ? 8'($urandom_range(1, 127))
                                            : 8'($urandom_range(1, 24)),
                   8'($urandom_range(1, 6)),
                   8'(256 - $urandom_range(1, 24)),
                   8'($urandom_range(1, 6)),
                   8'($urandom_range(1, 4)),
                   8'($urandom_range(0, 4)),
                   ($urandom_range(2) == 0) ? 8'($urandom_range(0, 32)) : 8'd32);
      endcase
      no_idle   = (p == 3);
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) random_burst();
    end
    no_idle = 1'b0;

    settle();
    $display("Covered %0d words (%0d checked) over %0d register writes.",
             words_sent, words_checked, reg_writes);
    $display("Snapshot requests: %0d, out-of-range results: %0d, mismatches: %0d.",
             snaps_seen, invalid_seen, mismatches);
    if (mismatches == 0)
      $display("fault_code_status_debounce_aging_core verification clean");
    else
      $display("fault_code_status_debounce_aging_core verification failed");
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #5_000_000;
    $display("fault_code_status_debounce_aging_core verification failed");
    $finish;
  end

endmodule
